// ===== src/indexed_counter_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the indexed counter table.
// Define NO_ASSERTIONS to compile all checks out.
// ----------------------------------------------------------------------------
`ifndef INDEXED_COUNTER_TABLE_TOP_DEFINES_SVH
`define INDEXED_COUNTER_TABLE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition that must hold at every clock edge outside reset.
`define ICT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define ICT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ICT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define ICT_ASSERT_ALWAYS(lbl, cond, msg)
`define ICT_ASSERT_SAME(lbl, ante, cons, msg)
`define ICT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/ict_pkg.sv =====
// ----------------------------------------------------------------------------
// ict_pkg
// Types and constants shared by the indexed counter table modules.
// ----------------------------------------------------------------------------
package ict_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = 12;
    localparam int CNT_W       = 13;
    localparam int DATA_W      = 64;

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_SET    = 3'd1,
        MODE_GET    = 3'd2,
        MODE_ADD    = 3'd3,
        MODE_CLEAR  = 3'd4,
        MODE_SIZE   = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DATA_W-1:0] t_word;

endpackage

// ===== src/ict_ram.sv =====
// ----------------------------------------------------------------------------
// ict_ram
// Single-clock entry store: one write port and one registered read port.
// A read and a write to the same address in one cycle return the old word.
// ----------------------------------------------------------------------------
module ict_ram
    import ict_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rd_en,
    input  t_idx  i_rd_addr,
    output t_word o_rd_data,
    input  logic  i_wr_en,
    input  t_idx  i_wr_addr,
    input  t_word i_wr_data
);

    t_word r_mem [TABLE_DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/indexed_counter_table_top.sv =====
// ----------------------------------------------------------------------------
// indexed_counter_table_top
// Table of 64-bit words with a fill count: append, set, get, add, clear, size.
// ----------------------------------------------------------------------------
// An item is held in the execute stage, its result in the output register.
// Throughput: one item per cycle when not stalled, set by the single read port
// of the entry store; a write in the same cycle as the next read is forwarded.
// A stalled result holds the item behind it in the execute stage.
// Reset clears the fill count and empties both stages; the entry store is
// not cleared, as no entry is read before it has been appended.
`include "indexed_counter_table_top_defines.svh"

module indexed_counter_table_top
    import ict_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_mode,
    input  logic [IDX_W-1:0]       i_index,
    input  logic [DATA_W-1:0]      i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_status,
    output logic [DATA_W-1:0]      o_read_value,
    output logic [CNT_W-1:0]       o_position
);

    // Execute stage.
    logic    r_busy, n_busy;
    t_mode   r_mode;
    t_idx    r_index;
    t_word   r_value;
    logic    r_fwd;
    t_word   r_fwd_data;

    // Table state.
    t_cnt    r_fill, n_fill;

    // Output register.
    logic    r_out_valid, n_out_valid;
    t_status r_status;
    t_word   r_read_value;
    t_cnt    r_position;

    logic    in_xfer;
    logic    complete;
    logic    in_range;
    logic    full;
    t_word   operand;
    t_word   rd_data;
    logic    wr_en;
    t_idx    wr_addr;
    t_word   wr_data;
    t_status x_status;
    t_word   x_read_value;
    t_cnt    x_position;

    assign complete   = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy || complete;
    assign in_xfer    = i_in_valid && o_in_ready;

    ict_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_rd_addr (i_index),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign operand  = r_fwd ? r_fwd_data : rd_data;
    assign in_range = {1'b0, r_index} < r_fill;
    assign full     = r_fill == CNT_W'(TABLE_DEPTH);

    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = r_index;
        wr_data      = r_value;
        x_status     = ST_OK;
        x_read_value = '0;
        x_position   = '0;
        n_fill       = r_fill;
        unique case (r_mode)
            MODE_APPEND: begin
                if (full) begin
                    x_status = ST_FULL;
                end else begin
                    wr_en      = complete;
                    wr_addr    = r_fill[IDX_W-1:0];
                    x_position = r_fill;
                    if (complete) begin
                        n_fill = r_fill + CNT_W'(1);
                    end
                end
            end
            MODE_SET: begin
                if (in_range) begin
                    wr_en = complete;
                end else begin
                    x_status = ST_RANGE;
                end
            end
            MODE_GET: begin
                if (in_range) begin
                    x_read_value = operand;
                end else begin
                    x_status = ST_RANGE;
                end
            end
            MODE_ADD: begin
                if (in_range) begin
                    wr_en   = complete;
                    wr_data = operand + r_value;
                end else begin
                    x_status = ST_RANGE;
                end
            end
            MODE_CLEAR: begin
                if (complete) begin
                    n_fill = '0;
                end
            end
            MODE_SIZE: begin
                x_position = r_fill;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        if (in_xfer) begin
            n_busy = 1'b1;
        end else if (complete) begin
            n_busy = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (complete) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_fill      <= n_fill;
        end
    end

    // The store reads the old word when it is written in the same cycle, so
    // the word being written is kept for the following item.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode     <= t_mode'(i_mode);
            r_index    <= i_index;
            r_value    <= i_value;
            r_fwd      <= wr_en && (wr_addr == i_index);
            r_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (complete) begin
            r_status     <= x_status;
            r_read_value <= x_read_value;
            r_position   <= x_position;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;
    assign o_position   = r_position;

    `ICT_ASSERT_ALWAYS(a_fill_bound, r_fill <= CNT_W'(TABLE_DEPTH), "fill count beyond depth")
    `ICT_ASSERT_NEXT(a_append_count, complete && r_mode == MODE_APPEND && !full, r_fill == $past(r_fill) + CNT_W'(1), "append did not advance fill count")
    `ICT_ASSERT_NEXT(a_stall_holds, r_busy && r_out_valid && !i_out_ready, r_busy && r_out_valid, "item lost while result stalled")
    `ICT_ASSERT_SAME(a_write_gated, wr_en, complete && (in_range || r_mode == MODE_APPEND), "entry written without completion")

endmodule
